### src/wssl_pkg.sv
// Shared types and constants for the WebAssembly custom-section locator.
// No dependencies; used by wssl_parser and wasm_signature_section_locator.
package wssl_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int NAME_BYTES_DEF    = 8;

  // Default section name, first character in the top byte
  localparam logic [63:0] SECTION_NAME_RESET = 64'h7477_6570_2E73_6967;

  localparam logic [7:0] LEB_DATA_MASK = 8'h7F;
  localparam logic [7:0] LEB_CONT_BIT  = 8'h80;

  localparam int OUT_TDATA_W = 104;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HEADER    = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_NONE      = 3'd3,
    ST_NOT_LAST  = 3'd4
  } status_t;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_ID      = 7'b0000010,
    PH_SIZE    = 7'b0000100,
    PH_NAMELEN = 7'b0001000,
    PH_NAME    = 7'b0010000,
    PH_SKIP    = 7'b0100000,
    PH_FOUND   = 7'b1000000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] prefix_length;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } res_t;

  // Module magic: 00 'a' 's' 'm'
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h61;
      2'd2:    b = 8'h73;
      default: b = 8'h6D;
    endcase
    return b;
  endfunction

endpackage

### src/wssl_parser.sv
// Byte-at-a-time section parser: header check, LEB128 sizes, name compare.
// Depends on wssl_pkg.
module wssl_parser #(
  parameter int POSITION_BITS = wssl_pkg::POSITION_BITS_DEF,
  parameter int NAME_BYTES    = wssl_pkg::NAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             is_last,
  input  logic [63:0]      section_name,
  output wssl_pkg::res_t   res
);

  localparam int PW = POSITION_BITS + 1;
  localparam int SW = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;
  localparam logic [SW-1:0] END_LIMIT  = SW'(1) << POSITION_BITS;
  localparam logic [31:0]   NAME_COUNT = 32'(NAME_BYTES);
  localparam logic [3:0]    NAME_LAST  = 4'(NAME_BYTES);

  wssl_pkg::phase_t  phase_r, phase_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [31:0]       leb_val_r, leb_val_nxt;
  logic [2:0]        leb_cnt_r, leb_cnt_nxt;
  logic [PW-1:0]     sec_begin_r, sec_begin_nxt;
  logic [PW-1:0]     sec_finish_r, sec_finish_nxt;
  logic              custom_r, custom_nxt;
  logic [PW-1:0]     name_finish_r, name_finish_nxt;
  logic [3:0]        name_idx_r, name_idx_nxt;
  logic              name_match_r, name_match_nxt;
  logic              found_r, found_nxt;
  wssl_pkg::status_t err_r, err_nxt;

  logic          pos_ovf;
  logic [PW-1:0] pos_inc;
  logic          at_end;
  logic [6:0]    part;
  logic          leb_more;
  logic [4:0]    leb_sh;
  logic [31:0]   leb_new;
  logic          leb_bad;
  logic          leb_done;
  logic [SW-1:0] end_sum;
  logic [7:0]    name_exp;
  logic          match_now;
  logic [PW-1:0] pay_len;
  wssl_pkg::status_t fin_status;

  assign pos_ovf  = pos_r[POSITION_BITS];
  assign pos_inc  = pos_r + PW'(1);
  assign at_end   = (pos_inc >= sec_finish_r);
  assign part     = 7'(data_byte & wssl_pkg::LEB_DATA_MASK);
  assign leb_more = |(data_byte & wssl_pkg::LEB_CONT_BIT);
  assign name_exp = 8'(section_name >> {~name_idx_r[2:0], 3'b000});
  assign match_now = name_match_r && (data_byte == name_exp);

  // One LEB128 group per byte; the fifth byte carries only four value bits
  always_comb begin
    case (leb_cnt_r[1:0])
      2'd0:    leb_sh = 5'd0;
      2'd1:    leb_sh = 5'd7;
      2'd2:    leb_sh = 5'd14;
      default: leb_sh = 5'd21;
    endcase
    if (leb_cnt_r[2]) begin
      leb_new  = leb_val_r | {part[3:0], 28'b0};
      leb_bad  = leb_more || (part[6:4] != 3'b000);
      leb_done = !leb_bad;
    end else begin
      leb_new  = leb_val_r | (32'(part) << leb_sh);
      leb_bad  = 1'b0;
      leb_done = !leb_more;
    end
  end

  assign end_sum = SW'(pos_inc) + SW'(leb_new);

  always_comb begin
    phase_nxt       = phase_r;
    leb_val_nxt     = leb_val_r;
    leb_cnt_nxt     = leb_cnt_r;
    sec_begin_nxt   = sec_begin_r;
    sec_finish_nxt  = sec_finish_r;
    custom_nxt      = custom_r;
    name_finish_nxt = name_finish_r;
    name_idx_nxt    = name_idx_r;
    name_match_nxt  = name_match_r;
    found_nxt       = found_r;
    err_nxt         = err_r;
    pos_nxt         = pos_ovf ? pos_r : pos_inc;

    if (err_r == wssl_pkg::ST_OK) begin
      if (pos_ovf) begin
        err_nxt = (phase_r == wssl_pkg::PH_FOUND) ? wssl_pkg::ST_NOT_LAST
                                                  : wssl_pkg::ST_MALFORMED;
      end else begin
        case (phase_r)
          wssl_pkg::PH_HEADER: begin
            if ((pos_r < PW'(4)) && (data_byte != wssl_pkg::magic_byte(pos_r[1:0]))) begin
              err_nxt = wssl_pkg::ST_HEADER;
            end else if (pos_r >= PW'(7)) begin
              phase_nxt = wssl_pkg::PH_ID;
            end
          end
          wssl_pkg::PH_ID: begin
            sec_begin_nxt = pos_r;
            custom_nxt    = (data_byte == 8'h00);
            leb_val_nxt   = '0;
            leb_cnt_nxt   = '0;
            phase_nxt     = wssl_pkg::PH_SIZE;
          end
          wssl_pkg::PH_SIZE: begin
            leb_val_nxt = leb_new;
            if (leb_bad) begin
              err_nxt = wssl_pkg::ST_MALFORMED;
            end else if (leb_done) begin
              sec_finish_nxt = end_sum[PW-1:0];
              if (end_sum > END_LIMIT) begin
                err_nxt = wssl_pkg::ST_MALFORMED;
              end else if (leb_new == 32'd0) begin
                phase_nxt = wssl_pkg::PH_ID;
              end else if (custom_r) begin
                leb_val_nxt = '0;
                leb_cnt_nxt = '0;
                phase_nxt   = wssl_pkg::PH_NAMELEN;
              end else begin
                phase_nxt = wssl_pkg::PH_SKIP;
              end
            end else begin
              leb_cnt_nxt = leb_cnt_r + 3'd1;
            end
          end
          wssl_pkg::PH_NAMELEN: begin
            leb_val_nxt = leb_new;
            if (leb_bad) begin
              phase_nxt = at_end ? wssl_pkg::PH_ID : wssl_pkg::PH_SKIP;
            end else if (leb_done) begin
              if ((end_sum > SW'(sec_finish_r)) || (leb_new != NAME_COUNT)) begin
                phase_nxt = at_end ? wssl_pkg::PH_ID : wssl_pkg::PH_SKIP;
              end else begin
                name_finish_nxt = end_sum[PW-1:0];
                name_idx_nxt    = '0;
                name_match_nxt  = 1'b1;
                phase_nxt       = wssl_pkg::PH_NAME;
              end
            end else begin
              leb_cnt_nxt = leb_cnt_r + 3'd1;
              if (at_end) begin
                phase_nxt = wssl_pkg::PH_ID;
              end
            end
          end
          wssl_pkg::PH_NAME: begin
            name_match_nxt = match_now;
            name_idx_nxt   = name_idx_r + 4'd1;
            if (name_idx_nxt >= NAME_LAST) begin
              if (match_now) begin
                found_nxt = 1'b1;
                phase_nxt = wssl_pkg::PH_FOUND;
              end else begin
                phase_nxt = at_end ? wssl_pkg::PH_ID : wssl_pkg::PH_SKIP;
              end
            end
          end
          wssl_pkg::PH_SKIP: begin
            if (at_end) begin
              phase_nxt = wssl_pkg::PH_ID;
            end
          end
          wssl_pkg::PH_FOUND: begin
            if (pos_r >= sec_finish_r) begin
              err_nxt = wssl_pkg::ST_NOT_LAST;
            end
          end
          default: begin
            err_nxt = wssl_pkg::ST_MALFORMED;
          end
        endcase
      end
    end
  end

  // Verdict on the last byte, from the updated state
  always_comb begin
    if (err_nxt != wssl_pkg::ST_OK) begin
      fin_status = err_nxt;
    end else if (phase_nxt == wssl_pkg::PH_HEADER) begin
      fin_status = wssl_pkg::ST_HEADER;
    end else if (phase_nxt == wssl_pkg::PH_ID) begin
      fin_status = wssl_pkg::ST_NONE;
    end else if ((phase_nxt == wssl_pkg::PH_FOUND) && found_nxt &&
                 (sec_finish_nxt == pos_inc)) begin
      fin_status = wssl_pkg::ST_OK;
    end else begin
      fin_status = wssl_pkg::ST_MALFORMED;
    end
  end

  assign pay_len = sec_finish_nxt - name_finish_nxt;

  always_comb begin
    res.status = fin_status;
    if (fin_status == wssl_pkg::ST_OK) begin
      res.prefix_length  = 32'(SW'(sec_begin_nxt));
      res.payload_offset = 32'(SW'(name_finish_nxt));
      res.payload_length = 32'(SW'(pay_len));
    end else begin
      res.prefix_length  = '0;
      res.payload_offset = '0;
      res.payload_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      phase_r       <= wssl_pkg::PH_HEADER;
      pos_r         <= '0;
      leb_val_r     <= '0;
      leb_cnt_r     <= '0;
      sec_begin_r   <= '0;
      sec_finish_r  <= '0;
      custom_r      <= 1'b0;
      name_finish_r <= '0;
      name_idx_r    <= '0;
      name_match_r  <= 1'b0;
      found_r       <= 1'b0;
      err_r         <= wssl_pkg::ST_OK;
    end else if (step) begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      leb_val_r     <= leb_val_nxt;
      leb_cnt_r     <= leb_cnt_nxt;
      sec_begin_r   <= sec_begin_nxt;
      sec_finish_r  <= sec_finish_nxt;
      custom_r      <= custom_nxt;
      name_finish_r <= name_finish_nxt;
      name_idx_r    <= name_idx_nxt;
      name_match_r  <= name_match_nxt;
      found_r       <= found_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

### src/wasm_signature_section_locator.sv
// Top level of the WebAssembly custom-section locator: stream ports, config
// register, input and result registers. Depends on wssl_pkg and wssl_parser.
//
// Usage:
//  - in_* carries the module one byte per beat; in_tlast marks its final byte.
//  - On the final byte one result beat leaves on out_*: status, the offset of
//    the matching section's id byte, and the offset and length of the payload
//    that follows the section name. Offsets are zero unless status is OK.
//  - cfg_* writes the 64-bit section name (first character in the top byte);
//    only the top NAME_BYTES bytes are compared. Write it between modules.
// Path: an accepted byte is held in the input register; the last byte is
//   parsed into the result register once that register is free, and the
//   result beat leaves from it on out_*.
// Throughput: one byte per cycle through the parse step between the input
//   and result registers; a final byte waits while a result is held.
// Reset: rst_n (synchronous) empties both registers, restores the default
//   section name and returns the parser to the header phase. The parser also
//   returns to that phase after each final byte, ready for the next module.
// Stall: a held result stalls a final byte waiting behind it and the bytes
//   after it; other bytes keep flowing while out_tready is low.
module wasm_signature_section_locator #(
  parameter int POSITION_BITS = wssl_pkg::POSITION_BITS_DEF,
  parameter int NAME_BYTES    = wssl_pkg::NAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // is_last
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] status, [34:3] prefix_length, [66:35] payload_offset,
  // [98:67] payload_length, [103:99] zero
  output logic [wssl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // config write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [63:0]                      cfg_data    // section_name
);

  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           in_last_r;
  logic           out_valid_r;
  wssl_pkg::res_t out_res_r;
  logic [63:0]    name_r;
  logic           step;
  wssl_pkg::res_t res;

  // A non-final byte never needs the result register
  assign step      = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  wssl_parser #(
    .POSITION_BITS (POSITION_BITS),
    .NAME_BYTES    (NAME_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_byte_r),
    .is_last      (in_last_r),
    .section_name (name_r),
    .res          (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (step && in_last_r) begin
      out_res_r <= res;
    end
  end

  // section name register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= wssl_pkg::SECTION_NAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      name_r <= cfg_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_res_r.payload_length, out_res_r.payload_offset,
                       out_res_r.prefix_length, out_res_r.status};

endmodule
